>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int BYTE_BITS = 8;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_BIT_PHASE   = 2'd1;
  localparam logic [1:0] REG_EDGE_HOLD   = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] BIT_PHASE_RST   = 8'd2;
  localparam logic [7:0] EDGE_HOLD_RST   = 8'd4;

  // Raw action codes on the request stream
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;
  localparam logic [2:0] ACT_WAIT  = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT_ACK
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic [7:0] ack_timeout_ticks;
    logic [7:0] bit_phase_ticks;
    logic [7:0] edge_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       ack_missing;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

>>> rtl/i2cm_front.sv
`timescale 1ns / 1ps
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  item_t      dec;
  logic       push, pop;

  // Classify the raw action; unused codes become plain ticks
  always_comb begin
    unique case (in_tdata[2:0])
      ACT_START: dec.cmd = CMD_START;
      ACT_STOP:  dec.cmd = CMD_STOP;
      ACT_WRITE: dec.cmd = CMD_WRITE;
      ACT_READ:  dec.cmd = CMD_READ;
      ACT_WAIT:  dec.cmd = CMD_WAIT_ACK;
      default:   dec.cmd = CMD_NONE;
    endcase
    dec.tx_byte     = in_tdata[10:3];
    dec.ack_to_send = in_tdata[11];
    dec.sda_sample  = in_tdata[12];
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> rtl/i2cm_back.sv
`timescale 1ns / 1ps
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START_HI, ST_START_LO, ST_STOP_LO, ST_STOP_HI,
    ST_WR_SETUP, ST_WR_HIGH, ST_WR_LOW, ST_RD_LOW, ST_RD_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_WA_REL, ST_WA_HIGH
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [7:0] tmo_r, tmo_nxt;
  logic       pend_ack_r, pend_ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       dir_r, dir_nxt;
  logic [7:0] rx_hold_r, rx_hold_nxt;
  logic       miss_r, miss_nxt;
  logic       done;
  logic       do_enter;
  state_t     ent;
  logic [3:0] bit_inc;
  logic [7:0] seg;
  logic       out_valid_r;
  result_t    out_r, res;
  logic       step;

  assign q_ready    = !out_valid_r || out_tready;
  assign step       = q_valid && q_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};
  assign bit_inc    = bit_idx_r + 4'd1;

  always_comb begin
    state_nxt    = state_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    timer_nxt    = timer_r;
    tmo_nxt      = tmo_r;
    pend_ack_nxt = pend_ack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    dir_nxt      = dir_r;
    rx_hold_nxt  = rx_hold_r;
    miss_nxt     = miss_r;
    done         = 1'b0;
    do_enter     = 1'b0;
    ent          = ST_IDLE;
    seg          = 8'd0;

    if (state_r == ST_IDLE || state_r > ST_WA_HIGH) begin
      state_nxt = ST_IDLE;
      unique case (q_item.cmd)
        CMD_START: begin
          do_enter = 1'b1;
          ent      = ST_START_HI;
        end
        CMD_STOP: begin
          do_enter = 1'b1;
          ent      = ST_STOP_LO;
        end
        CMD_WRITE: begin
          bit_idx_nxt = 4'd0;
          shift_nxt   = q_item.tx_byte;
          do_enter    = 1'b1;
          ent         = ST_WR_SETUP;
        end
        CMD_READ: begin
          bit_idx_nxt  = 4'd0;
          shift_nxt    = 8'd0;
          pend_ack_nxt = q_item.ack_to_send;
          do_enter     = 1'b1;
          ent          = ST_RD_LOW;
        end
        CMD_WAIT_ACK: begin
          tmo_nxt  = 8'd0;
          miss_nxt = 1'b0;
          do_enter = 1'b1;
          ent      = ST_WA_REL;
        end
        default: ;
      endcase
    end else if (timer_r != 8'd0) begin
      timer_nxt = timer_r - 8'd1;
    end else begin
      unique case (state_r)
        ST_START_HI: begin do_enter = 1'b1; ent = ST_START_LO; end
        ST_START_LO: begin
          scl_nxt   = 1'b0;
          state_nxt = ST_IDLE;
          timer_nxt = 8'd0;
          done      = 1'b1;
        end
        ST_STOP_LO: begin do_enter = 1'b1; ent = ST_STOP_HI; end
        ST_STOP_HI: begin
          state_nxt = ST_IDLE;
          timer_nxt = 8'd0;
          done      = 1'b1;
        end
        ST_WR_SETUP: begin do_enter = 1'b1; ent = ST_WR_HIGH; end
        ST_WR_HIGH:  begin do_enter = 1'b1; ent = ST_WR_LOW; end
        ST_WR_LOW: begin
          bit_idx_nxt = bit_inc;
          if (bit_inc < 4'(BYTE_BITS)) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            do_enter  = 1'b1;
            ent       = ST_WR_SETUP;
          end else begin
            state_nxt = ST_IDLE;
            timer_nxt = 8'd0;
            done      = 1'b1;
          end
        end
        ST_RD_LOW: begin do_enter = 1'b1; ent = ST_RD_HIGH; end
        ST_RD_HIGH: begin
          bit_idx_nxt = bit_inc;
          do_enter    = 1'b1;
          ent         = (bit_inc < 4'(BYTE_BITS)) ? ST_RD_LOW : ST_ACK_LOW;
        end
        ST_ACK_LOW: begin do_enter = 1'b1; ent = ST_ACK_HIGH; end
        ST_ACK_HIGH: begin
          scl_nxt     = 1'b0;
          rx_hold_nxt = shift_r;
          state_nxt   = ST_IDLE;
          timer_nxt   = 8'd0;
          done        = 1'b1;
        end
        ST_WA_REL: begin do_enter = 1'b1; ent = ST_WA_HIGH; end
        ST_WA_HIGH: begin
          if (!q_item.sda_sample) begin
            scl_nxt   = 1'b0;
            state_nxt = ST_IDLE;
            timer_nxt = 8'd0;
            done      = 1'b1;
          end else if (tmo_r >= cfg.ack_timeout_ticks) begin
            // timed out: flag it and send a stop
            miss_nxt = 1'b1;
            do_enter = 1'b1;
            ent      = ST_STOP_LO;
          end else begin
            tmo_nxt = tmo_r + 8'd1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
          timer_nxt = 8'd0;
        end
      endcase
    end

    // Load the new segment: its levels and its length
    if (do_enter) begin
      state_nxt = ent;
      if (ent == ST_START_HI || ent == ST_START_LO || ent == ST_STOP_LO ||
          ent == ST_STOP_HI) begin
        seg = cfg.edge_hold_ticks;
      end else begin
        seg = cfg.bit_phase_ticks;
      end
      timer_nxt = (seg == 8'd0) ? 8'd0 : seg - 8'd1;
      unique case (ent)
        ST_START_HI: begin dir_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; end
        ST_START_LO: sda_nxt = 1'b0;
        ST_STOP_LO:  begin dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0; end
        ST_STOP_HI:  begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        ST_WR_SETUP: begin dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; end
        ST_RD_LOW:   begin dir_nxt = 1'b0; scl_nxt = 1'b0; end
        ST_ACK_LOW:  begin dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = !pend_ack_nxt; end
        ST_WA_REL:   begin dir_nxt = 1'b0; sda_nxt = 1'b1; end
        ST_WR_HIGH, ST_RD_HIGH, ST_ACK_HIGH, ST_WA_HIGH: scl_nxt = 1'b1;
        ST_WR_LOW:   scl_nxt = 1'b0;
        default: ;
      endcase
    end

    // Sample the data bit on the last tick of SCL high
    if (state_nxt == ST_RD_HIGH && timer_nxt == 8'd0) begin
      shift_nxt = {shift_nxt[6:0], q_item.sda_sample};
    end

    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.sda_drive   = dir_nxt;
    res.busy_res    = (state_nxt != ST_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_hold_nxt;
    res.ack_missing = miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'd0;
      timer_r     <= 8'd0;
      tmo_r       <= 8'd0;
      pend_ack_r  <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      dir_r       <= 1'b1;
      rx_hold_r   <= 8'd0;
      miss_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r    <= state_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        timer_r    <= timer_nxt;
        tmo_r      <= tmo_nxt;
        pend_ack_r <= pend_ack_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        dir_r      <= dir_nxt;
        rx_hold_r  <= rx_hold_nxt;
        miss_r     <= miss_nxt;
      end
      if (q_ready) begin
        out_valid_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

endmodule

>>> rtl/i2c_master_bit_engine_top.sv
`timescale 1ns / 1ps
// I2C master bit engine: one request is one bus tick, one result per request.
// An accepted request is written into a queue slot; the tick logic then loads its result
// into the output register once that register is empty or out_tready is high.
// Throughput: one request per cycle while out_tready is high, set by the tick update.
// Reset (rst_n low, synchronous): queue empty, controller idle, SCL/SDA driven high.
module i2c_master_bit_engine_top
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // action[2:0], tx_byte[10:3], ack_to_send[11], sda_sample[12]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
                                  // done_res[4], rx_byte[12:5], ack_missing[13]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       q_valid;
  logic       q_ready;
  item_t      q_item;

  // Configuration registers: written on the access phase, never stall
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACK_TIMEOUT: cfg_nxt.ack_timeout_ticks = cfg_pwdata[7:0];
        REG_BIT_PHASE:   cfg_nxt.bit_phase_ticks   = cfg_pwdata[7:0];
        REG_EDGE_HOLD:   cfg_nxt.edge_hold_ticks   = cfg_pwdata[7:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACK_TIMEOUT: cfg_prdata = {24'd0, cfg_r.ack_timeout_ticks};
      REG_BIT_PHASE:   cfg_prdata = {24'd0, cfg_r.bit_phase_ticks};
      REG_EDGE_HOLD:   cfg_prdata = {24'd0, cfg_r.edge_hold_ticks};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RST;
      cfg_r.bit_phase_ticks   <= BIT_PHASE_RST;
      cfg_r.edge_hold_ticks   <= EDGE_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: take requests, decode the action, park them in a two-entry queue
  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // Back: advance the bus state machine one tick per request, register the result
  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
